### sv/block_arena_allocator_with_marks_assert.svh
// Assertion macros for the block arena allocator.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef BLOCK_ARENA_ALLOCATOR_WITH_MARKS_ASSERT_SVH
`define BLOCK_ARENA_ALLOCATOR_WITH_MARKS_ASSERT_SVH
`ifndef SYNTHESIS
`define BAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BAM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BAM_ASSERT(lbl, prop, msg)
`define BAM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/bam_pkg.sv
// Shared types and constants of the block arena allocator.
// No dependencies.
`timescale 1ns / 1ps
package bam_pkg;

    localparam int OP_W   = 3;
    localparam int AMT_W  = 24;
    localparam int CFG_W  = 24;
    localparam int STAT_W = 2;
    localparam int BLK_W  = 4;
    localparam int OFS_W  = 31;

    localparam logic [CFG_W-1:0] CFG_RESET = 24'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_EXTEND = 3'd1,
        OP_SHRINK = 3'd2,
        OP_PUSH   = 3'd3,
        OP_POP    = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_MARK_EMPTY = 2'd2,
        ST_MARK_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_NEW,
        S_CUR,
        S_POP_SB,
        S_POP_CLR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [AMT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [BLK_W-1:0] block_index;
        logic [OFS_W-1:0] offset;
        logic [OFS_W-1:0] remaining;
    } rsp_t;

endpackage

### sv/bam_if.sv
// Handshake interfaces for the request, response and configuration channels.
// Depends on bam_pkg for the field widths.
`timescale 1ns / 1ps
interface bam_req_if;
    logic                       valid;
    logic                       ready;
    logic [bam_pkg::OP_W-1:0]   op;
    logic [bam_pkg::AMT_W-1:0]  amount;
    modport source (output valid, op, amount, input ready);
    modport sink (input valid, op, amount, output ready);
endinterface

interface bam_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bam_pkg::STAT_W-1:0] status;
    logic [bam_pkg::BLK_W-1:0]  block_index;
    logic [bam_pkg::OFS_W-1:0]  offset;
    logic [bam_pkg::OFS_W-1:0]  remaining;
    modport source (output valid, status, block_index, offset, remaining, input ready);
    modport sink (input valid, status, block_index, offset, remaining, output ready);
endinterface

interface bam_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bam_pkg::CFG_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### sv/block_arena_allocator_with_marks.sv
// Extend, shrink, push, unknown ops and alloc that fits the current block go from the
// request beat through S_CUR (or S_SCAN for alloc) to S_RESP. Alloc reads further blocks
// in S_SCAN, may add one in S_NEW; pop adds S_POP_SB and an S_POP_CLR per cleared block.
// The next request beat is taken after the result is loaded into the output register,
// which waits while the output holds an unaccepted result; one request is in flight.
// After reset and after each configuration beat S_INIT writes block 0.
`timescale 1ns / 1ps
module block_arena_allocator_with_marks #(
    parameter int MAX_BLOCKS = 16,
    parameter int MARK_DEPTH = 16,
    parameter int SIZE_BITS  = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    bam_req_if.sink   req,
    bam_rsp_if.source rsp,
    bam_cfg_if.sink   cfg
);
    import bam_pkg::*;

    req_t req_beat;
    rsp_t res;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic res_valid;
    logic res_ready;

    assign req_beat.op     = req.op;
    assign req_beat.amount = req.amount;
    assign res_ready       = !rsp_valid_reg || rsp.ready;

    bam_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MARK_DEPTH (MARK_DEPTH),
        .SIZE_BITS  (SIZE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg.data),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req       (req_beat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .rsp       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_reg.status;
    assign rsp.block_index = rsp_reg.block_index;
    assign rsp.offset      = rsp_reg.offset;
    assign rsp.remaining   = rsp_reg.remaining;

endmodule

### sv/bam_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bam_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/bam_seq.sv
// Sequencer of the block arena allocator: block table and mark stack RAMs,
// arena registers and the read-modify-write control. Depends on bam_pkg and bam_ram.
`timescale 1ns / 1ps
`include "block_arena_allocator_with_marks_assert.svh"
module bam_seq #(
    parameter int MAX_BLOCKS = 16,
    parameter int MARK_DEPTH = 16,
    parameter int SIZE_BITS  = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bam_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bam_pkg::req_t             req,
    output logic                      res_valid,
    input  logic                      res_ready,
    output bam_pkg::rsp_t             rsp
);
    import bam_pkg::*;

    localparam int BW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int MIW  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int DW   = $clog2(MARK_DEPTH + 1);
    localparam int AW   = ((SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W) + 1;
    localparam int BE_W = 2 * SIZE_BITS;
    localparam int ME_W = BW + SIZE_BITS;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [AW-1:0]        amt_reg, amt_next;
    logic [CFG_W-1:0]     first_reg, first_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [BW-1:0]        cur_reg, cur_next;
    logic [DW-1:0]        md_reg, md_next;
    logic [BW-1:0]        idx_reg, idx_next;
    logic [SIZE_BITS-1:0] cs_reg, cs_next;
    logic [SIZE_BITS-1:0] cf_reg, cf_next;
    logic [BW-1:0]        sb_reg, sb_next;
    logic [SIZE_BITS-1:0] sf_reg, sf_next;
    status_t              res_status_reg, res_status_next;
    logic [BW-1:0]        res_blk_reg, res_blk_next;
    logic [SIZE_BITS-1:0] res_off_reg, res_off_next;
    logic [SIZE_BITS-1:0] res_rem_reg, res_rem_next;

    logic                 bt_we;
    logic [BW-1:0]        bt_waddr;
    logic [SIZE_BITS-1:0] bt_wsize;
    logic [SIZE_BITS-1:0] bt_wfill;
    logic [BW-1:0]        bt_raddr;
    logic [BE_W-1:0]      bt_rdata;
    logic                 mk_we;
    logic [MIW-1:0]       mk_waddr;
    logic [ME_W-1:0]      mk_wdata;
    logic [MIW-1:0]       mk_raddr;
    logic [ME_W-1:0]      mk_rdata;

    logic [SIZE_BITS-1:0] d_size, d_fill, d_room, shr_fill, sf_clamp;
    logic [AW-1:0]        room_x, sum_x, left_x, fill_x, cs_x, max_x, ns_x;
    logic                 fits, ns_ovf, tbl_full, scan_more, mark_full;
    logic [BW-1:0]        mk_blk, sb_clamp;
    logic [SIZE_BITS-1:0] mk_fill;

    bam_ram #(
        .DATA_W (BE_W),
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (BW)
    ) u_block_ram (
        .clk   (clk),
        .we    (bt_we),
        .waddr (bt_waddr),
        .wdata ({bt_wsize, bt_wfill}),
        .raddr (bt_raddr),
        .rdata (bt_rdata)
    );

    bam_ram #(
        .DATA_W (ME_W),
        .DEPTH  (MARK_DEPTH),
        .ADDR_W (MIW)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    always_comb
    begin
        d_size    = bt_rdata[BE_W-1:SIZE_BITS];
        d_fill    = bt_rdata[SIZE_BITS-1:0];
        d_room    = d_size - d_fill;
        room_x    = AW'(d_room);
        fill_x    = AW'(d_fill);
        fits      = amt_reg <= room_x;
        sum_x     = fill_x + amt_reg;
        left_x    = room_x - amt_reg;
        shr_fill  = (fill_x > amt_reg) ? SIZE_BITS'(fill_x - amt_reg) : '0;
        cs_x      = AW'(cs_reg);
        max_x     = (cs_x > amt_reg) ? cs_x : amt_reg;
        ns_x      = max_x << 1;
        ns_ovf    = |ns_x[AW-1:SIZE_BITS];
        tbl_full  = cnt_reg >= CW'(MAX_BLOCKS);
        scan_more = (CW'(idx_reg) + CW'(1)) < cnt_reg;
        mark_full = md_reg >= DW'(MARK_DEPTH);
        mk_blk    = mk_rdata[ME_W-1:SIZE_BITS];
        mk_fill   = mk_rdata[SIZE_BITS-1:0];
        sb_clamp  = (CW'(mk_blk) >= cnt_reg) ? BW'(cnt_reg - CW'(1)) : mk_blk;
        sf_clamp  = (sf_reg > d_size) ? d_size : sf_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        amt_next        = amt_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        md_next         = md_reg;
        idx_next        = idx_reg;
        cs_next         = cs_reg;
        cf_next         = cf_reg;
        sb_next         = sb_reg;
        sf_next         = sf_reg;
        res_status_next = res_status_reg;
        res_blk_next    = res_blk_reg;
        res_off_next    = res_off_reg;
        res_rem_next    = res_rem_reg;
        bt_we           = 1'b0;
        bt_waddr        = idx_reg;
        bt_wsize        = d_size;
        bt_wfill        = d_fill;
        bt_raddr        = cur_reg;
        mk_we           = 1'b0;
        mk_waddr        = MIW'(md_reg);
        mk_wdata        = {cur_reg, d_fill};
        mk_raddr        = MIW'(md_reg - DW'(1));
        in_ready        = 1'b0;
        cfg_ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                bt_we      = 1'b1;
                bt_waddr   = '0;
                bt_wsize   = SIZE_BITS'(first_reg);
                bt_wfill   = '0;
                cnt_next   = CW'(1);
                cur_next   = '0;
                md_next    = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                priority if (cfg_valid)
                begin
                    first_next = cfg_data;
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    op_next    = op_t'(req.op);
                    amt_next   = AW'(req.amount);
                    idx_next   = cur_reg;
                    state_next = (op_t'(req.op) == OP_ALLOC) ? S_SCAN : S_CUR;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == cur_reg)
                begin
                    cs_next = d_size;
                    cf_next = d_fill;
                end
                priority if (fits)
                begin
                    bt_we           = 1'b1;
                    bt_wfill        = SIZE_BITS'(sum_x);
                    cur_next        = idx_reg;
                    res_status_next = ST_OK;
                    res_blk_next    = idx_reg;
                    res_off_next    = d_fill;
                    res_rem_next    = SIZE_BITS'(left_x);
                    state_next      = S_RESP;
                end
                else if (scan_more)
                begin
                    idx_next = idx_reg + BW'(1);
                    bt_raddr = idx_reg + BW'(1);
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_NEW:
            begin
                if (tbl_full || ns_ovf)
                begin
                    res_status_next = ST_NO_ROOM;
                    res_blk_next    = cur_reg;
                    res_off_next    = cf_reg;
                    res_rem_next    = cs_reg - cf_reg;
                end
                else
                begin
                    bt_we           = 1'b1;
                    bt_waddr        = BW'(cnt_reg);
                    bt_wsize        = SIZE_BITS'(ns_x);
                    bt_wfill        = SIZE_BITS'(amt_reg);
                    cnt_next        = cnt_reg + CW'(1);
                    cur_next        = BW'(cnt_reg);
                    res_status_next = ST_OK;
                    res_blk_next    = BW'(cnt_reg);
                    res_off_next    = '0;
                    res_rem_next    = SIZE_BITS'(ns_x - amt_reg);
                end
                state_next = S_RESP;
            end
            S_CUR:
            begin
                bt_waddr        = cur_reg;
                res_status_next = ST_OK;
                res_blk_next    = cur_reg;
                res_off_next    = d_fill;
                res_rem_next    = d_room;
                state_next      = S_RESP;
                unique case (op_reg)
                    OP_EXTEND:
                    begin
                        if (!fits)
                        begin
                            res_status_next = ST_NO_ROOM;
                        end
                        else
                        begin
                            bt_we        = 1'b1;
                            bt_wfill     = SIZE_BITS'(sum_x);
                            res_off_next = SIZE_BITS'(sum_x);
                            res_rem_next = SIZE_BITS'(left_x);
                        end
                    end
                    OP_SHRINK:
                    begin
                        bt_we        = 1'b1;
                        bt_wfill     = shr_fill;
                        res_off_next = shr_fill;
                        res_rem_next = d_size - shr_fill;
                    end
                    OP_PUSH:
                    begin
                        if (mark_full)
                        begin
                            res_status_next = ST_MARK_FULL;
                        end
                        else
                        begin
                            mk_we   = 1'b1;
                            md_next = md_reg + DW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (md_reg == '0)
                        begin
                            res_status_next = ST_MARK_EMPTY;
                        end
                        else
                        begin
                            md_next    = md_reg - DW'(1);
                            sb_next    = sb_clamp;
                            sf_next    = mk_fill;
                            bt_raddr   = sb_clamp;
                            state_next = S_POP_SB;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_POP_SB:
            begin
                bt_we           = 1'b1;
                bt_waddr        = sb_reg;
                bt_wfill        = sf_clamp;
                res_status_next = ST_OK;
                res_blk_next    = sb_reg;
                res_off_next    = sf_clamp;
                res_rem_next    = d_size - sf_clamp;
                if (sb_reg < cur_reg)
                begin
                    idx_next   = sb_reg + BW'(1);
                    bt_raddr   = sb_reg + BW'(1);
                    state_next = S_POP_CLR;
                end
                else
                begin
                    cur_next   = sb_reg;
                    state_next = S_RESP;
                end
            end
            S_POP_CLR:
            begin
                bt_we    = 1'b1;
                bt_wfill = '0;
                if (idx_reg < cur_reg)
                begin
                    idx_next = idx_reg + BW'(1);
                    bt_raddr = idx_reg + BW'(1);
                end
                else
                begin
                    cur_next   = sb_reg;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            first_reg <= CFG_RESET;
            cnt_reg   <= CW'(1);
            cur_reg   <= '0;
            md_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            md_reg    <= md_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        amt_reg        <= amt_next;
        idx_reg        <= idx_next;
        cs_reg         <= cs_next;
        cf_reg         <= cf_next;
        sb_reg         <= sb_next;
        sf_reg         <= sf_next;
        res_status_reg <= res_status_next;
        res_blk_reg    <= res_blk_next;
        res_off_reg    <= res_off_next;
        res_rem_reg    <= res_rem_next;
    end

    assign rsp.status      = res_status_reg;
    assign rsp.block_index = BLK_W'(res_blk_reg);
    assign rsp.offset      = OFS_W'(res_off_reg);
    assign rsp.remaining   = OFS_W'(res_rem_reg);

    `BAM_ASSERT(a_cur_below_count, CW'(cur_reg) < cnt_reg, "current block beyond block count")
    `BAM_ASSERT(a_count_range, (cnt_reg != '0) && (cnt_reg <= CW'(MAX_BLOCKS)), "block count out of range")
    `BAM_ASSERT(a_depth_range, md_reg <= DW'(MARK_DEPTH), "mark depth beyond stack size")
    `BAM_ASSERT(a_count_stable, ((state_reg != S_NEW) && (state_reg != S_INIT)) |=> $stable(cnt_reg), "block count changed outside block creation")

endmodule
